FILE: design/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg: shared constants for the three-plane intersection block
// Default widths, queue depth, the cofactor wiring tables and the
// back-end sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tpi_pkg;

  localparam int unsigned COEF_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Entries between the determinant pipeline and the divider.
  localparam int unsigned QDEPTH = 4;

  // Column codes of the augmented matrix: a, b, c and the right-hand side.
  localparam logic [1:0] COL_A = 2'd0;
  localparam logic [1:0] COL_B = 2'd1;
  localparam logic [1:0] COL_C = 2'd2;
  localparam logic [1:0] COL_R = 2'd3;

  // The six 2x2 minors of rows two and three, one per column pair (p, q).
  localparam logic [1:0] PAIR_P [6] = '{COL_A, COL_A, COL_A, COL_B, COL_B, COL_C};
  localparam logic [1:0] PAIR_Q [6] = '{COL_B, COL_C, COL_R, COL_C, COL_R, COL_R};

  // First-row expansion of D, Dx, Dy, Dz: row-one element, minor and sign.
  localparam logic [1:0] TERM_COL [4][3] = '{
    '{COL_A, COL_B, COL_C},
    '{COL_R, COL_B, COL_C},
    '{COL_A, COL_R, COL_C},
    '{COL_A, COL_B, COL_R}
  };
  localparam logic [2:0] TERM_PAIR [4][3] = '{
    '{3'd3, 3'd1, 3'd0},
    '{3'd3, 3'd5, 3'd4},
    '{3'd5, 3'd1, 3'd2},
    '{3'd4, 3'd2, 3'd0}
  };
  localparam logic TERM_NEG [4][3] = '{
    '{1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b0, 1'b1},
    '{1'b1, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b0}
  };

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } bk_state_e;

endpackage

`default_nettype wire

FILE: design/three_plane_intersection.sv
// ----------------------------------------------------------------------------
// three_plane_intersection: intersection point of three planes
// Cramer's rule in exact fixed point with saturated Q-format results.
// ----------------------------------------------------------------------------
// Usage. A word of three planes (a, b, c, d per plane) is taken at a clock
// edge where start_i is high and busy_o is low. For each word one result is
// shown on the point and flag ports for exactly one cycle, marked by done_o;
// the receiver cannot hold it off, and results come out in input order.
//
// The front pipeline forms the four determinants in registered stages and can
// take a word every cycle while busy_o is low. A four-entry queue then feeds
// the quotient unit, which runs three restoring dividers side by side at one
// quotient bit per cycle on DW = 3*COEF_WIDTH + 7 bit determinants. A regular
// word is divided in BK_DIV and finished in BK_FIN; a singular word is done
// straight from BK_IDLE, so the divider loop sets the sustained rate. A word
// passes the pipeline and the queue, is popped in BK_IDLE, and its result and
// done_o are registered in BK_FIN, or on the pop itself for a singular word.
// busy_o rises when the words in the pipeline and queue fill the queue.
//
// Reset empties the pipeline and the queue and returns the divider to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module three_plane_intersection import tpi_pkg::*; #(
  parameter int unsigned COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  [COEF_WIDTH-1:0]        p1_nx_i,
  input  wire  [COEF_WIDTH-1:0]        p1_ny_i,
  input  wire  [COEF_WIDTH-1:0]        p1_nz_i,
  input  wire  [COEF_WIDTH-1:0]        p1_off_i,
  input  wire  [COEF_WIDTH-1:0]        p2_nx_i,
  input  wire  [COEF_WIDTH-1:0]        p2_ny_i,
  input  wire  [COEF_WIDTH-1:0]        p2_nz_i,
  input  wire  [COEF_WIDTH-1:0]        p2_off_i,
  input  wire  [COEF_WIDTH-1:0]        p3_nx_i,
  input  wire  [COEF_WIDTH-1:0]        p3_ny_i,
  input  wire  [COEF_WIDTH-1:0]        p3_nz_i,
  input  wire  [COEF_WIDTH-1:0]        p3_off_i,
  output logic                         done_o,
  output logic signed [COEF_WIDTH-1:0] point_x_o,
  output logic signed [COEF_WIDTH-1:0] point_y_o,
  output logic signed [COEF_WIDTH-1:0] point_z_o,
  output logic                         singular_o,
  output logic                         saturated_o
);

  localparam int unsigned DW = 3 * COEF_WIDTH + 7;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic [COEF_WIDTH-1:0] coef [12];
  logic                  accept;
  logic                  f_valid;
  logic signed [DW-1:0]  f_det [4];
  logic signed [DW-1:0]  q_det [4];
  logic                  q_empty, q_full, pop;
  logic signed [COEF_WIDTH-1:0] point [3];
  logic [CW-1:0]         pend_q, pend_d;

  assign coef = '{p1_nx_i, p1_ny_i, p1_nz_i, p1_off_i,
                  p2_nx_i, p2_ny_i, p2_nz_i, p2_off_i,
                  p3_nx_i, p3_ny_i, p3_nz_i, p3_off_i};

  // Words in the front pipeline or the queue; holding this at the queue depth
  // guarantees a queue slot for every word that leaves the pipeline.
  assign accept = start_i && !busy_o;
  assign busy_o = (pend_q == CW'(QDEPTH));
  assign pend_d = pend_q + CW'(accept) - CW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  tpi_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .coef_i  (coef),
    .valid_o (f_valid),
    .det_o   (f_det)
  );

  tpi_queue #(.DW(DW), .DEPTH(QDEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_det),
    .pop_i   (pop),
    .empty_o (q_empty),
    .full_o  (q_full),
    .data_o  (q_det)
  );

  tpi_back #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (!q_empty),
    .det_i       (q_det),
    .pop_o       (pop),
    .done_o      (done_o),
    .point_o     (point),
    .singular_o  (singular_o),
    .saturated_o (saturated_o)
  );

  assign point_x_o = point[0];
  assign point_y_o = point[1];
  assign point_z_o = point[2];

  // The pending count never exceeds the queue depth.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CW'(QDEPTH))
    else $error("pending word count beyond queue depth");

  // A word leaving the pipeline always finds room in the queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid |-> !q_full)
    else $error("queue overflow");

  // A singular result carries a zero point and no saturation.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |->
      (point_x_o == '0 && point_y_o == '0 && point_z_o == '0 && !saturated_o))
    else $error("singular result with nonzero point");

  // The divider only pops words that are there.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: design/tpi_front.sv
// ----------------------------------------------------------------------------
// tpi_front: determinant pipeline
// Three stages form the 2x2 minors and the four 3x3 determinants exactly.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_front import tpi_pkg::*; #(
  parameter int unsigned COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int unsigned EW = COEF_WIDTH + 1,
  localparam int unsigned PW = 2 * EW,
  localparam int unsigned MW = PW + 1,
  localparam int unsigned XW = 2 * EW + 1,
  localparam int unsigned DW = 3 * EW + 4
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         valid_i,
  input  wire  [COEF_WIDTH-1:0]       coef_i [12],
  output logic                        valid_o,
  output logic signed [DW-1:0]        det_o [4]
);

  logic signed [EW-1:0] el [3][4];
  logic signed [EW-1:0] row1_q [4];
  logic signed [PW-1:0] prd_q [6][2];
  logic signed [MW-1:0] minor [6];
  logic signed [EW:0]   m_hi [6];
  logic signed [EW:0]   m_lo [6];
  logic signed [XW-1:0] ph_q [4][3];
  logic signed [XW-1:0] pl_q [4][3];
  logic signed [DW-1:0] det_d [4];
  logic signed [DW-1:0] det_q [4];
  logic v1_q, v2_q, v3_q;

  // The right-hand side is the negated constant term, one bit wider.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        el[k][j] = $signed({coef_i[4*k+j][COEF_WIDTH-1], coef_i[4*k+j]});
      end
      el[k][3] = -$signed({coef_i[4*k+3][COEF_WIDTH-1], coef_i[4*k+3]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      prd_q[i][0] <= el[1][PAIR_P[i]] * el[2][PAIR_Q[i]];
      prd_q[i][1] <= el[1][PAIR_Q[i]] * el[2][PAIR_P[i]];
    end
    for (int j = 0; j < 4; j++) begin
      row1_q[j] <= el[0][j];
    end
  end

  // Each minor is split into a signed high part and an unsigned low part so
  // that the outer products stay one word by one word.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      minor[i] = MW'(prd_q[i][0]) - MW'(prd_q[i][1]);
      m_hi[i]  = minor[i][MW-1:EW];
      m_lo[i]  = $signed({1'b0, minor[i][EW-1:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 4; d++) begin
      for (int t = 0; t < 3; t++) begin
        ph_q[d][t] <= row1_q[TERM_COL[d][t]] * m_hi[TERM_PAIR[d][t]];
        pl_q[d][t] <= row1_q[TERM_COL[d][t]] * m_lo[TERM_PAIR[d][t]];
      end
    end
  end

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      det_d[d] = '0;
      for (int t = 0; t < 3; t++) begin
        if (TERM_NEG[d][t]) begin
          det_d[d] = det_d[d] - ((DW'(ph_q[d][t]) <<< EW) + DW'(pl_q[d][t]));
        end else begin
          det_d[d] = det_d[d] + ((DW'(ph_q[d][t]) <<< EW) + DW'(pl_q[d][t]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    det_q <= det_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign det_o   = det_q;

endmodule

`default_nettype wire

FILE: design/tpi_queue.sv
// ----------------------------------------------------------------------------
// tpi_queue: short queue of determinant sets
// Holds finished determinants until the divider is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_queue import tpi_pkg::*; #(
  parameter int unsigned DW    = 3 * COEF_WIDTH_DEF + 7,
  parameter int unsigned DEPTH = QDEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire  signed [DW-1:0]  data_i [4],
  input  wire                   pop_i,
  output logic                  empty_o,
  output logic                  full_o,
  output logic signed [DW-1:0]  data_o [4]
);

  logic signed [DW-1:0] mem_q [DEPTH][4];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign data_o  = mem_q[rd_q];

endmodule

`default_nettype wire

FILE: design/tpi_back.sv
// ----------------------------------------------------------------------------
// tpi_back: Cramer quotient unit
// Three restoring dividers, one bit per cycle, then saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_back import tpi_pkg::*; #(
  parameter int unsigned COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned DW = 3 * COEF_WIDTH + 7,
  localparam int unsigned NB = DW + FRAC_BITS,
  localparam int unsigned CW = $clog2(NB + 1)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          avail_i,
  input  wire  signed [DW-1:0]         det_i [4],
  output logic                         pop_o,
  output logic                         done_o,
  output logic signed [COEF_WIDTH-1:0] point_o [3],
  output logic                         singular_o,
  output logic                         saturated_o
);

  localparam int unsigned W = COEF_WIDTH;

  bk_state_e state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic          zero_det, load, step, fin;

  logic [NB-1:0] num_q [3];
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q [3];
  logic [W:0]    quo_q [3];
  logic          big_q [3];
  logic          neg_q [3];

  logic [DW:0]   trial [3];
  logic          ge [3];
  logic          lane_sat [3];
  logic [W-1:0]  lane_val [3];

  logic                  done_q, sing_q, sat_q;
  logic signed [W-1:0]   pt_q [3];

  assign zero_det = (det_i[0] == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (avail_i && !zero_det) state_d = BK_DIV;
      BK_DIV:  if (cnt_q == CW'(1))      state_d = BK_FIN;
      BK_FIN:  state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    step  = 1'b0;
    fin   = 1'b0;
    case (state_q)
      BK_IDLE: pop_o = avail_i;
      BK_DIV:  step  = 1'b1;
      BK_FIN:  fin   = 1'b1;
      default: ;
    endcase
  end

  assign load = pop_o && !zero_det;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_q[k], num_q[k][NB-1]};
      ge[k]    = (trial[k] >= {1'b0, den_q});
      if (neg_q[k]) begin
        lane_sat[k] = big_q[k] || quo_q[k][W] || (quo_q[k][W-1] && (|quo_q[k][W-2:0]));
        lane_val[k] = lane_sat[k] ? {1'b1, {(W-1){1'b0}}} : -quo_q[k][W-1:0];
      end else begin
        lane_sat[k] = big_q[k] || quo_q[k][W] || quo_q[k][W-1];
        lane_val[k] = lane_sat[k] ? {1'b0, {(W-1){1'b1}}} : quo_q[k][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      den_q <= det_i[0][DW-1] ? DW'(-det_i[0]) : DW'(det_i[0]);
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= {(det_i[k+1][DW-1] ? DW'(-det_i[k+1]) : DW'(det_i[k+1])),
                     {FRAC_BITS{1'b0}}};
        neg_q[k] <= det_i[k+1][DW-1] ^ det_i[0][DW-1];
        rem_q[k] <= '0;
        quo_q[k] <= '0;
        big_q[k] <= 1'b0;
      end
    end else if (step) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= {num_q[k][NB-2:0], 1'b0};
        rem_q[k] <= ge[k] ? DW'(trial[k] - {1'b0, den_q}) : DW'(trial[k]);
        quo_q[k] <= {quo_q[k][W-1:0], ge[k]};
        big_q[k] <= big_q[k] | quo_q[k][W];
      end
    end
    if (pop_o && zero_det) begin
      for (int k = 0; k < 3; k++) pt_q[k] <= '0;
      sing_q <= 1'b1;
      sat_q  <= 1'b0;
    end else if (fin) begin
      for (int k = 0; k < 3; k++) pt_q[k] <= $signed(lane_val[k]);
      sing_q <= 1'b0;
      sat_q  <= lane_sat[0] | lane_sat[1] | lane_sat[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (pop_o && zero_det) || fin;
      if (load) begin
        cnt_q <= CW'(NB);
      end else if (step) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assign done_o      = done_q;
  assign point_o     = pt_q;
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire
